### rtl/ipag_pkg.sv
// shared types and postbyte form codes for the indexed address generator
`default_nettype none

package ipag_pkg;

    // index register select codes (postbyte bits 6:5)
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_U = 2'd2;
    localparam logic [1:0] SEL_S = 2'd3;

    // indexed form codes (postbyte bits 4:0 when bit 7 is set)
    localparam logic [4:0] FORM_POST_INC1  = 5'h00;
    localparam logic [4:0] FORM_POST_INC2  = 5'h01;
    localparam logic [4:0] FORM_PRE_DEC1   = 5'h02;
    localparam logic [4:0] FORM_PRE_DEC2   = 5'h03;
    localparam logic [4:0] FORM_NO_OFF     = 5'h04;
    localparam logic [4:0] FORM_ACC_B      = 5'h05;
    localparam logic [4:0] FORM_ACC_A      = 5'h06;
    localparam logic [4:0] FORM_OFF8       = 5'h08;
    localparam logic [4:0] FORM_OFF16      = 5'h09;
    localparam logic [4:0] FORM_ACC_D      = 5'h0B;
    localparam logic [4:0] FORM_PCR8       = 5'h0C;
    localparam logic [4:0] FORM_PCR16      = 5'h0D;
    localparam logic [4:0] FORM_POST_INC2I = 5'h11;
    localparam logic [4:0] FORM_PRE_DEC2I  = 5'h13;
    localparam logic [4:0] FORM_NO_OFFI    = 5'h14;
    localparam logic [4:0] FORM_ACC_BI     = 5'h15;
    localparam logic [4:0] FORM_ACC_AI     = 5'h16;
    localparam logic [4:0] FORM_OFF8I      = 5'h18;
    localparam logic [4:0] FORM_OFF16I     = 5'h19;
    localparam logic [4:0] FORM_ACC_DI     = 5'h1B;
    localparam logic [4:0] FORM_PCR8I      = 5'h1C;
    localparam logic [4:0] FORM_PCR16I     = 5'h1D;
    localparam logic [4:0] FORM_EXT_IND    = 5'h1F;

    // operands of one transaction
    typedef struct packed {
        logic [7:0]  postbyte;
        logic [15:0] reg_x;
        logic [15:0] reg_y;
        logic [15:0] reg_u;
        logic [15:0] reg_s;
        logic [15:0] acc_d;
        logic [15:0] next_pc;
        logic [15:0] extension_bytes_in;
    } operand_t;

    // decoded result of one transaction
    typedef struct packed {
        logic [15:0] pointer_address;
        logic        indirect;
        logic [1:0]  extension_count;
        logic [1:0]  index_select;
        logic        index_write;
        logic [15:0] index_new_value;
        logic        illegal;
    } result_t;

endpackage

`default_nettype wire

### rtl/ipag_decode.sv
// postbyte decode and effective address arithmetic
`default_nettype none

module ipag_decode
(
    input  wire ipag_pkg::operand_t op,
    output ipag_pkg::result_t       res
);

    logic [4:0]  form;
    logic [1:0]  sel;
    logic [15:0] r;
    logic [15:0] off5;
    logic [15:0] sext_b;
    logic [15:0] sext_a;
    logic [15:0] sext_e;
    logic [15:0] addr;
    logic [15:0] nv;
    logic [1:0]  cnt;
    logic        wr;
    logic        bad;

    assign form   = op.postbyte[4:0];
    assign sel    = op.postbyte[6:5];
    assign off5   = {{11{op.postbyte[4]}}, op.postbyte[4:0]};
    assign sext_b = {{8{op.acc_d[7]}}, op.acc_d[7:0]};
    assign sext_a = {{8{op.acc_d[15]}}, op.acc_d[15:8]};
    assign sext_e = {{8{op.extension_bytes_in[15]}}, op.extension_bytes_in[15:8]};

    // base register select
    always_comb
    begin
        case (sel)
            ipag_pkg::SEL_X: r = op.reg_x;
            ipag_pkg::SEL_Y: r = op.reg_y;
            ipag_pkg::SEL_U: r = op.reg_u;
            default:         r = op.reg_s;
        endcase
    end

    // form decode
    always_comb
    begin
        addr = 16'h0000;
        nv   = 16'h0000;
        cnt  = 2'd0;
        wr   = 1'b0;
        bad  = 1'b0;
        if (!op.postbyte[7])
        begin
            addr = r + off5;
        end
        else
        begin
            case (form)
                ipag_pkg::FORM_POST_INC1:
                begin
                    addr = r;
                    wr   = 1'b1;
                    nv   = r + 16'd1;
                end
                ipag_pkg::FORM_POST_INC2, ipag_pkg::FORM_POST_INC2I:
                begin
                    addr = r;
                    wr   = 1'b1;
                    nv   = r + 16'd2;
                end
                ipag_pkg::FORM_PRE_DEC1:
                begin
                    wr   = 1'b1;
                    nv   = r - 16'd1;
                    addr = r - 16'd1;
                end
                ipag_pkg::FORM_PRE_DEC2, ipag_pkg::FORM_PRE_DEC2I:
                begin
                    wr   = 1'b1;
                    nv   = r - 16'd2;
                    addr = r - 16'd2;
                end
                ipag_pkg::FORM_NO_OFF, ipag_pkg::FORM_NO_OFFI:
                    addr = r;
                ipag_pkg::FORM_ACC_B, ipag_pkg::FORM_ACC_BI:
                    addr = r + sext_b;
                ipag_pkg::FORM_ACC_A, ipag_pkg::FORM_ACC_AI:
                    addr = r + sext_a;
                ipag_pkg::FORM_OFF8, ipag_pkg::FORM_OFF8I:
                begin
                    cnt  = 2'd1;
                    addr = r + sext_e;
                end
                ipag_pkg::FORM_OFF16, ipag_pkg::FORM_OFF16I:
                begin
                    cnt  = 2'd2;
                    addr = r + op.extension_bytes_in;
                end
                ipag_pkg::FORM_ACC_D, ipag_pkg::FORM_ACC_DI:
                    addr = r + op.acc_d;
                ipag_pkg::FORM_PCR8, ipag_pkg::FORM_PCR8I:
                begin
                    cnt  = 2'd1;
                    addr = op.next_pc + sext_e + 16'd1;
                end
                ipag_pkg::FORM_PCR16, ipag_pkg::FORM_PCR16I:
                begin
                    cnt  = 2'd2;
                    addr = op.next_pc + op.extension_bytes_in + 16'd2;
                end
                ipag_pkg::FORM_EXT_IND:
                begin
                    cnt  = 2'd2;
                    addr = op.extension_bytes_in;
                end
                default:
                    bad = 1'b1;
            endcase
        end
    end

    // illegal postbytes clear every output but the select and set the illegal flag
    always_comb
    begin
        res.index_select    = sel;
        res.illegal         = bad;
        res.pointer_address = bad ? 16'h0000 : addr;
        res.indirect        = op.postbyte[7] & op.postbyte[4] & ~bad;
        res.extension_count = bad ? 2'd0 : cnt;
        res.index_write     = wr & ~bad;
        res.index_new_value = bad ? 16'h0000 : nv;
    end

endmodule

`default_nettype wire

### rtl/indexed_postbyte_address_generator.sv
// top level: input register, postbyte decode and result register
`default_nettype none

// channel  direction  handshake                 payload
// in       input      in_valid / in_stall       postbyte, registers, pc, extension bytes
// out      output     out_valid / out_stall     address, flags, index update
//
// each transaction passes through the operand register and then the result
// register, with the decode logic between them
// one transaction per cycle is sustained while out_stall stays low
// reset clears both valid flags; payload registers are not reset
// when out_stall holds a result, an empty operand register still takes one more

module indexed_postbyte_address_generator
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  postbyte,
    input  wire  [15:0] reg_x,
    input  wire  [15:0] reg_y,
    input  wire  [15:0] reg_u,
    input  wire  [15:0] reg_s,
    input  wire  [15:0] acc_d,
    input  wire  [15:0] next_pc,
    input  wire  [15:0] extension_bytes_in,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [15:0] pointer_address,
    output logic        indirect,
    output logic [1:0]  extension_count,
    output logic [1:0]  index_select,
    output logic        index_write,
    output logic [15:0] index_new_value,
    output logic        illegal
);

    ipag_pkg::operand_t op_reg;
    ipag_pkg::result_t  res_reg;
    ipag_pkg::result_t  res_next;
    logic               op_valid_reg;
    logic               res_valid_reg;
    logic               res_load;
    logic               op_load;

    // advance control
    assign res_load = ~res_valid_reg | ~out_stall;
    assign op_load  = ~op_valid_reg | res_load;
    assign in_stall = ~op_load;

    // operand register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (op_load)
        begin
            op_valid_reg <= in_valid;
        end
    end

    // operand register payload
    always_ff @(posedge clk)
    begin
        if (op_load && in_valid)
        begin
            op_reg.postbyte           <= postbyte;
            op_reg.reg_x              <= reg_x;
            op_reg.reg_y              <= reg_y;
            op_reg.reg_u              <= reg_u;
            op_reg.reg_s              <= reg_s;
            op_reg.acc_d              <= acc_d;
            op_reg.next_pc            <= next_pc;
            op_reg.extension_bytes_in <= extension_bytes_in;
        end
    end

    // decode
    ipag_decode u_decode
    (
        .op  (op_reg),
        .res (res_next)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= op_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (res_load && op_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // output transaction
    assign out_valid       = res_valid_reg;
    assign pointer_address = res_reg.pointer_address;
    assign indirect        = res_reg.indirect;
    assign extension_count = res_reg.extension_count;
    assign index_select    = res_reg.index_select;
    assign index_write     = res_reg.index_write;
    assign index_new_value = res_reg.index_new_value;
    assign illegal         = res_reg.illegal;

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the indexed postbyte address generator
module tb;

    // every defined indexed form, plain and indirect
    localparam int LEGAL_COUNT = 23;
    localparam logic [LEGAL_COUNT-1:0][4:0] LEGAL_FORMS = {
        ipag_pkg::FORM_POST_INC1, ipag_pkg::FORM_POST_INC2, ipag_pkg::FORM_PRE_DEC1,
        ipag_pkg::FORM_PRE_DEC2, ipag_pkg::FORM_NO_OFF, ipag_pkg::FORM_ACC_B,
        ipag_pkg::FORM_ACC_A, ipag_pkg::FORM_OFF8, ipag_pkg::FORM_OFF16,
        ipag_pkg::FORM_ACC_D, ipag_pkg::FORM_PCR8, ipag_pkg::FORM_PCR16,
        ipag_pkg::FORM_POST_INC2I, ipag_pkg::FORM_PRE_DEC2I, ipag_pkg::FORM_NO_OFFI,
        ipag_pkg::FORM_ACC_BI, ipag_pkg::FORM_ACC_AI, ipag_pkg::FORM_OFF8I,
        ipag_pkg::FORM_OFF16I, ipag_pkg::FORM_ACC_DI, ipag_pkg::FORM_PCR8I,
        ipag_pkg::FORM_PCR16I, ipag_pkg::FORM_EXT_IND
    };

    // undefined indexed forms
    localparam int ILLEGAL_COUNT = 9;
    localparam logic [ILLEGAL_COUNT-1:0][4:0] ILLEGAL_FORMS = {
        5'h07, 5'h0A, 5'h0E, 5'h0F, 5'h10, 5'h12, 5'h17, 5'h1A, 5'h1E
    };

    localparam int RANDOM_PER_PHASE = 390;
    localparam int STALL_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 8;
    localparam int PRINT_LIMIT      = 40;

    // one expected result together with the postbyte that caused it
    typedef struct packed {
        logic [7:0]        postbyte;
        ipag_pkg::result_t res;
    } address_expect_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_stall = 1'b0;
    ipag_pkg::operand_t drv_op = '0;

    logic        in_stall;
    logic        out_valid;
    logic [15:0] pointer_address;
    logic        indirect;
    logic [1:0]  extension_count;
    logic [1:0]  index_select;
    logic        index_write;
    logic [15:0] index_new_value;
    logic        illegal;

    ipag_pkg::operand_t operand_backlog[$];
    address_expect_t    address_expectations[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int results_seen   = 0;
    int illegal_seen   = 0;
    int indirect_seen  = 0;
    int update_seen    = 0;

    indexed_postbyte_address_generator i_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .postbyte           (drv_op.postbyte),
        .reg_x              (drv_op.reg_x),
        .reg_y              (drv_op.reg_y),
        .reg_u              (drv_op.reg_u),
        .reg_s              (drv_op.reg_s),
        .acc_d              (drv_op.acc_d),
        .next_pc            (drv_op.next_pc),
        .extension_bytes_in (drv_op.extension_bytes_in),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .pointer_address    (pointer_address),
        .indirect           (indirect),
        .extension_count    (extension_count),
        .index_select       (index_select),
        .index_write        (index_write),
        .index_new_value    (index_new_value),
        .illegal            (illegal)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] sign_extend_byte(logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    // expected address, flags and index update for one postbyte
    function automatic ipag_pkg::result_t decode_postbyte(ipag_pkg::operand_t op);
        ipag_pkg::result_t res;
        logic [15:0]       base;
        logic [4:0]        form;
        logic              bad;
        res = '0;
        bad = 1'b0;
        form = op.postbyte[4:0];
        case (op.postbyte[6:5])
            ipag_pkg::SEL_X: base = op.reg_x;
            ipag_pkg::SEL_Y: base = op.reg_y;
            ipag_pkg::SEL_U: base = op.reg_u;
            default:         base = op.reg_s;
        endcase
        if (!op.postbyte[7])
        begin
            // 5-bit signed offset form
            res.pointer_address = base + {{11{form[4]}}, form};
        end
        else
        begin
            case (form)
                ipag_pkg::FORM_POST_INC1:
                begin
                    res.pointer_address = base;
                    res.index_write = 1'b1;
                    res.index_new_value = base + 16'd1;
                end
                ipag_pkg::FORM_POST_INC2, ipag_pkg::FORM_POST_INC2I:
                begin
                    res.pointer_address = base;
                    res.index_write = 1'b1;
                    res.index_new_value = base + 16'd2;
                end
                ipag_pkg::FORM_PRE_DEC1:
                begin
                    res.index_write = 1'b1;
                    res.index_new_value = base - 16'd1;
                    res.pointer_address = res.index_new_value;
                end
                ipag_pkg::FORM_PRE_DEC2, ipag_pkg::FORM_PRE_DEC2I:
                begin
                    res.index_write = 1'b1;
                    res.index_new_value = base - 16'd2;
                    res.pointer_address = res.index_new_value;
                end
                ipag_pkg::FORM_NO_OFF, ipag_pkg::FORM_NO_OFFI:
                    res.pointer_address = base;
                ipag_pkg::FORM_ACC_B, ipag_pkg::FORM_ACC_BI:
                    res.pointer_address = base + sign_extend_byte(op.acc_d[7:0]);
                ipag_pkg::FORM_ACC_A, ipag_pkg::FORM_ACC_AI:
                    res.pointer_address = base + sign_extend_byte(op.acc_d[15:8]);
                ipag_pkg::FORM_OFF8, ipag_pkg::FORM_OFF8I:
                begin
                    res.extension_count = 2'd1;
                    res.pointer_address = base
                        + sign_extend_byte(op.extension_bytes_in[15:8]);
                end
                ipag_pkg::FORM_OFF16, ipag_pkg::FORM_OFF16I:
                begin
                    res.extension_count = 2'd2;
                    res.pointer_address = base + op.extension_bytes_in;
                end
                ipag_pkg::FORM_ACC_D, ipag_pkg::FORM_ACC_DI:
                    res.pointer_address = base + op.acc_d;
                ipag_pkg::FORM_PCR8, ipag_pkg::FORM_PCR8I:
                begin
                    res.extension_count = 2'd1;
                    res.pointer_address = op.next_pc + 16'd1
                        + sign_extend_byte(op.extension_bytes_in[15:8]);
                end
                ipag_pkg::FORM_PCR16, ipag_pkg::FORM_PCR16I:
                begin
                    res.extension_count = 2'd2;
                    res.pointer_address = op.next_pc + 16'd2 + op.extension_bytes_in;
                end
                ipag_pkg::FORM_EXT_IND:
                begin
                    res.extension_count = 2'd2;
                    res.pointer_address = op.extension_bytes_in;
                end
                default:
                    bad = 1'b1;
            endcase
            // undefined forms clear everything but the select and set the illegal flag
            if (bad)
            begin
                res = '0;
                res.illegal = 1'b1;
            end
            else
            begin
                res.indirect = op.postbyte[4];
            end
        end
        res.index_select = op.postbyte[6:5];
        return res;
    endfunction

    // random word biased toward the wraparound corners
    function automatic logic [15:0] random_word();
        logic [15:0] w;
        w = 16'($urandom_range(65535));
        if ($urandom_range(99) < 20)
        begin
            case ($urandom_range(5))
                0:       w = 16'h0000;
                1:       w = 16'h0001;
                2:       w = 16'h7FFF;
                3:       w = 16'h8000;
                4:       w = 16'hFFFE;
                default: w = 16'hFFFF;
            endcase
        end
        return w;
    endfunction

    // mostly defined indexed forms, some undefined ones, some raw bytes
    function automatic logic [7:0] random_postbyte();
        int         pick;
        logic [1:0] sel;
        pick = $urandom_range(99);
        sel = 2'($urandom_range(3));
        if (pick < 60)
            return {1'b1, sel, LEGAL_FORMS[$urandom_range(LEGAL_COUNT - 1)]};
        else if (pick < 75)
            return {1'b1, sel, ILLEGAL_FORMS[$urandom_range(ILLEGAL_COUNT - 1)]};
        else
            return 8'($urandom_range(255));
    endfunction

    // style 0 random registers, 1 and 2 two fixed corner sets
    task automatic queue_operand(logic [7:0] pb, int style);
        ipag_pkg::operand_t op;
        op.postbyte = pb;
        if (style == 1)
        begin
            op.reg_x = 16'h0000; op.reg_y = 16'h0001; op.reg_u = 16'h8000;
            op.reg_s = 16'h7FFF; op.acc_d = 16'h807F; op.next_pc = 16'hFFFF;
            op.extension_bytes_in = 16'h80FF;
        end
        else if (style == 2)
        begin
            op.reg_x = 16'hFFFF; op.reg_y = 16'hFFFE; op.reg_u = 16'h7FFF;
            op.reg_s = 16'h8000; op.acc_d = 16'h7F80; op.next_pc = 16'h0000;
            op.extension_bytes_in = 16'h7F00;
        end
        else
        begin
            op.reg_x = random_word(); op.reg_y = random_word();
            op.reg_u = random_word(); op.reg_s = random_word();
            op.acc_d = random_word(); op.next_pc = random_word();
            op.extension_bytes_in = random_word();
        end
        operand_backlog.push_back(op);
    endtask

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(logic [7:0] pb, string field, logic [15:0] got,
                               logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("postbyte %h %s got %h expected %h",
                                      pb, field, got, want));
    endtask

    // wait until every queued transaction has its result back
    task automatic drain();
        while (operand_backlog.size() != 0 || in_valid
               || address_expectations.size() != 0)
            @(negedge clk);
    endtask

    // driver: present the next operand once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                address_expectations.push_back({drv_op.postbyte, decode_postbyte(drv_op)});
            if (!in_valid || !in_stall)
            begin
                if (operand_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_op <= operand_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        address_expect_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (address_expectations.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, address %h",
                                              pointer_address));
                end
                else
                begin
                    want = address_expectations.pop_front();
                    check_field(want.postbyte, "pointer_address", pointer_address,
                                want.res.pointer_address);
                    check_field(want.postbyte, "indirect", 16'(indirect),
                                16'(want.res.indirect));
                    check_field(want.postbyte, "extension_count", 16'(extension_count),
                                16'(want.res.extension_count));
                    check_field(want.postbyte, "index_select", 16'(index_select),
                                16'(want.res.index_select));
                    check_field(want.postbyte, "index_write", 16'(index_write),
                                16'(want.res.index_write));
                    check_field(want.postbyte, "index_new_value", index_new_value,
                                want.res.index_new_value);
                    check_field(want.postbyte, "illegal", 16'(illegal),
                                16'(want.res.illegal));
                    results_seen++;
                    if (want.res.illegal)
                        illegal_seen++;
                    if (want.res.indirect)
                        indirect_seen++;
                    if (want.res.index_write)
                        update_seen++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("indexed_postbyte_address_generator verification failed");
                $finish;
            end
        end
    end

    // stimulus and phase control
    initial
    begin
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: 5-bit offsets at both signs, every plain form, special forms
        queue_operand({1'b0, ipag_pkg::SEL_X, 5'h0F}, 1);
        queue_operand({1'b0, ipag_pkg::SEL_Y, 5'h10}, 1);
        queue_operand({1'b0, ipag_pkg::SEL_S, 5'h1F}, 2);
        for (int i = 0; i < LEGAL_COUNT; i++)
        begin
            if (!LEGAL_FORMS[i][4])
                queue_operand({1'b1, 2'(i), LEGAL_FORMS[i]}, (i % 2) + 1);
        end
        // extended indirect ignores the register select
        queue_operand({1'b1, ipag_pkg::SEL_X, ipag_pkg::FORM_EXT_IND}, 1);
        queue_operand({1'b1, ipag_pkg::SEL_S, ipag_pkg::FORM_EXT_IND}, 2);
        for (int i = 0; i < ILLEGAL_COUNT; i++)
            queue_operand({1'b1, 2'(i), ILLEGAL_FORMS[i]}, (i % 2) + 1);
        drain();

        // random: no idling, sender gaps, receiver stalls, both
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 49 : (phase == 3) ? 11 : 0;
            recv_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 11 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                queue_operand(random_postbyte(), 0);
            // sender holds off here until the block has emptied
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("checked %0d results: %0d illegal, %0d indirect, %0d index updates",
                 results_seen, illegal_seen, indirect_seen, update_seen);
        $display("pacing: free running, sender gaps, receiver stalls and both mixed");
        if (mismatch_count == 0)
        begin
            $display("indexed_postbyte_address_generator verification clean");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("indexed_postbyte_address_generator verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ipag_pkg.sv
rtl/ipag_decode.sv
rtl/indexed_postbyte_address_generator.sv
dv/tb.sv
